>>> sv/edtc_pkg.sv
// Shared types and constants for the echo distance block.
// No dependencies; used by edtc_ctrl, edtc_dp and echo_distance_temp_comp.
package edtc_pkg;

  // speed of sound, mm/s
  localparam logic [18:0] SPEED_DEFAULT = 19'd343200;
  localparam logic [18:0] SPEED_LOW     = 19'd200000;
  localparam logic [18:0] SPEED_HIGH    = 19'd400000;

  // 0 degC in milli-kelvin, and 331300^2
  localparam logic [19:0] KELVIN_MC = 20'd273150;
  localparam logic [36:0] BASE_SQ   = 37'd109759690000;

  // configuration reset values
  localparam logic [29:0] FREQ_RESET = 30'd1000000;
  localparam logic [23:0] MIN_RESET  = 24'd20000;
  localparam logic [23:0] MAX_RESET  = 24'd4000000;

  // serial unit lengths
  localparam int MUL_STEPS  = 28;
  localparam int DIV_STEPS  = 60;
  localparam int SQRT_STEPS = 20;
  localparam int CNT_W      = 6;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_ECHO  = 3'd1;
  localparam logic [2:0] ST_BLANKING = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_TEMP     = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_TIMER_FREQ = 2'd0;
  localparam logic [1:0] CFG_MIN_RANGE  = 2'd1;
  localparam logic [1:0] CFG_MAX_RANGE  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_SQRT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_step;
    logic div_step;
    logic sqrt_step;
    logic sqrt_first;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_temp;
    logic early;
  } sts_t;

endpackage

>>> sv/edtc_ctrl.sv
// Sequencer for the echo distance block: steps the serial multiply, divide
// and square root of edtc_dp and owns the input/output handshakes. Uses edtc_pkg.
module edtc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  edtc_pkg::sts_t sts,
  output edtc_pkg::cmd_t cmd
);
  import edtc_pkg::*;

  localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(MUL_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (sts.early) begin
          state_next = S_DONE;
        end else begin
          cmd.mul_step = 1'b1;
          if (cnt == MUL_LAST) begin
            cnt_next   = '0;
            state_next = S_DIV;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == DIV_LAST) begin
          cnt_next   = '0;
          state_next = sts.is_temp ? S_SQRT : S_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step  = 1'b1;
        cmd.sqrt_first = (cnt == '0);
        if (cnt == SQRT_LAST) begin
          cnt_next   = '0;
          state_next = S_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

>>> sv/edtc_dp.sv
// Datapath of the echo distance block: shift-add multiplier, restoring divider,
// digit-by-digit square root, stored speed of sound and result register. Uses edtc_pkg.
module edtc_dp (
  input  logic           clk,
  input  logic           rst,
  input  edtc_pkg::cmd_t cmd,
  output edtc_pkg::sts_t sts,
  input  logic           kind,
  input  logic [31:0]    echo_ticks,
  input  logic [17:0]    temp_millic,
  input  logic [29:0]    tick_rate_hz,
  input  logic [23:0]    min_range_um,
  input  logic [23:0]    max_range_um,
  output logic [23:0]    distance_um,
  output logic [2:0]     status,
  output logic [18:0]    sound_speed_mm_s
);
  import edtc_pkg::*;

  logic [18:0] speed;
  logic        is_temp;
  logic        early;
  logic [2:0]  early_code;
  logic [18:0] speed_use_r;
  logic [36:0] mcand;
  logic [27:0] mplier;
  logic [29:0] divisor;
  logic [59:0] acc;
  logic [29:0] rem;
  logic [19:0] root;

  logic [18:0] speed_use;
  logic [27:0] sp28;
  logic [27:0] mpl_echo;
  logic [19:0] kelvin;
  logic [59:0] mul_acc;
  logic [30:0] div_rs;
  logic [30:0] div_dv;
  logic        div_ge;
  logic [30:0] div_diff;
  logic [20:0] sq_rem_in;
  logic [19:0] sq_root_in;
  logic [22:0] sq_rs;
  logic [22:0] sq_trial;
  logic        sq_ge;
  logic [22:0] sq_diff;
  logic        round_up;
  logic [20:0] new_root;
  logic [18:0] new_speed;
  logic        blank;
  logic        over;

  assign sts.is_temp = is_temp;
  assign sts.early   = early;

  // out-of-limit stored speed falls back to the default for echoes
  assign speed_use = (speed < SPEED_LOW || speed > SPEED_HIGH) ? SPEED_DEFAULT : speed;
  assign sp28      = 28'(speed_use);
  assign mpl_echo  = (sp28 << 9) - (sp28 << 3) - (sp28 << 2); // x500
  assign kelvin    = KELVIN_MC + {{2{temp_millic[17]}}, temp_millic};

  // MSB-first shift-add
  assign mul_acc = {acc[58:0], 1'b0} + (mplier[27] ? 60'(mcand) : 60'd0);

  // restoring divide, quotient shifts into acc
  assign div_rs   = {rem, acc[59]};
  assign div_dv   = {1'b0, divisor};
  assign div_ge   = (div_rs >= div_dv);
  assign div_diff = div_rs - div_dv;

  // radicand is the quotient, below 2^40; two bits per step from acc[39:38]
  assign sq_rem_in  = cmd.sqrt_first ? 21'd0 : rem[20:0];
  assign sq_root_in = cmd.sqrt_first ? 20'd0 : root;
  assign sq_rs      = {sq_rem_in, acc[39:38]};
  assign sq_trial   = {1'b0, sq_root_in, 2'b01};
  assign sq_ge      = (sq_rs >= sq_trial);
  assign sq_diff    = sq_rs - sq_trial;

  // round to nearest: remainder x - r^2 above r
  assign round_up  = (rem[20:0] > {1'b0, root});
  assign new_root  = {1'b0, root} + 21'(round_up);
  assign new_speed = new_root[18:0];

  assign blank = (acc < {36'd0, min_range_um});
  assign over  = (acc > {36'd0, max_range_um});

  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= SPEED_DEFAULT;
    end else if (cmd.out_load && is_temp) begin
      speed <= new_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_temp     <= kind;
      speed_use_r <= speed_use;
      acc         <= '0;
      rem         <= '0;
      if (kind) begin
        early      <= 1'b0;
        early_code <= ST_TEMP;
        mcand      <= BASE_SQ;
        mplier     <= 28'(kelvin[18:0]);
        divisor    <= 30'(KELVIN_MC);
      end else begin
        early      <= (echo_ticks == '0) || (tick_rate_hz == '0);
        early_code <= (echo_ticks == '0) ? ST_NO_ECHO : ST_RANGE;
        mcand      <= 37'(echo_ticks);
        mplier     <= mpl_echo;
        divisor    <= tick_rate_hz;
      end
    end
    if (cmd.mul_step) begin
      acc    <= mul_acc;
      mplier <= {mplier[26:0], 1'b0};
    end
    if (cmd.div_step) begin
      acc <= {acc[58:0], div_ge};
      rem <= div_ge ? div_diff[29:0] : div_rs[29:0];
    end
    if (cmd.sqrt_step) begin
      acc  <= {acc[57:0], 2'b00};
      rem  <= 30'(sq_ge ? sq_diff : sq_rs);
      root <= {sq_root_in[18:0], sq_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (is_temp) begin
        distance_um      <= '0;
        status           <= ST_TEMP;
        sound_speed_mm_s <= new_speed;
      end else begin
        sound_speed_mm_s <= speed_use_r;
        if (early) begin
          distance_um <= '0;
          status      <= early_code;
        end else if (blank) begin
          distance_um <= '0;
          status      <= ST_BLANKING;
        end else if (over) begin
          distance_um <= '0;
          status      <= ST_RANGE;
        end else begin
          distance_um <= acc[23:0];
          status      <= ST_OK;
        end
      end
    end
  end

endmodule

>>> sv/echo_distance_temp_comp.sv
// Ultrasonic echo distance with temperature-compensated speed of sound.
// Top level: configuration registers, edtc_ctrl and edtc_dp. Uses edtc_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready): kind 0 carries echo_ticks, kind 1
//   carries temp_millic. Each accepted beat gives exactly one result beat on
//   the output channel (out_valid/out_ready): distance_um, status and
//   sound_speed_mm_s.
//   Config channel (cfg_valid/cfg_ready): cfg_index selects timer frequency,
//   blanking distance or maximum distance; always ready, write only when idle.
// Timing: one item at a time through a shared serial datapath. An echo takes
//   a shift-add multiply and a restoring divide; a temperature adds a square
//   root. Zero ticks or zero timer frequency skips the arithmetic and goes
//   straight to the result. The next item is taken in the cycle after its
//   predecessor is loaded into the output register.
// Reset: speed of sound returns to 343200 mm/s, registers to their defaults,
//   output empty. A stalled receiver holds the result; the next item is still
//   accepted and runs until it needs the output register.
module echo_distance_temp_comp (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [31:0] echo_ticks,
  input  logic [17:0] temp_millic,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] distance_um,
  output logic [2:0]  status,
  output logic [18:0] sound_speed_mm_s,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [29:0] cfg_data
);
  import edtc_pkg::*;

  logic [29:0] tick_rate_hz;
  logic [23:0] min_range_um;
  logic [23:0] max_range_um;
  cmd_t        cmd;
  sts_t        sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate_hz <= FREQ_RESET;
      min_range_um <= MIN_RESET;
      max_range_um <= MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TIMER_FREQ: tick_rate_hz <= cfg_data;
        CFG_MIN_RANGE:  min_range_um <= cfg_data[23:0];
        CFG_MAX_RANGE:  max_range_um <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  edtc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  edtc_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .kind             (kind),
    .echo_ticks       (echo_ticks),
    .temp_millic      (temp_millic),
    .tick_rate_hz     (tick_rate_hz),
    .min_range_um     (min_range_um),
    .max_range_um     (max_range_um),
    .distance_um      (distance_um),
    .status           (status),
    .sound_speed_mm_s (sound_speed_mm_s)
  );

`ifndef SYNTHESIS
  // one item in flight: no second beat right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_ok_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OK) |->
      (distance_um >= min_range_um && distance_um <= max_range_um))
    else $error("ok distance outside configured range");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (distance_um == '0))
    else $error("rejected result carries a distance");

  a_echo_speed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_TEMP) |->
      (sound_speed_mm_s >= SPEED_LOW && sound_speed_mm_s <= SPEED_HIGH))
    else $error("echo used a speed outside limits");
`endif

endmodule
